>>> rtl/core/stream_table_merge_assert.svh
// ---------------------------------------------------------------------------
// stream_table_merge_assert.svh
// Assertion macros shared by the stream table merge RTL.
// ---------------------------------------------------------------------------
`ifndef STREAM_TABLE_MERGE_ASSERT_SVH
`define STREAM_TABLE_MERGE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define STM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define STM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/stm_pkg.sv
// ---------------------------------------------------------------------------
// stm_pkg
// Types and constants for the stream table merge block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stm_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = 6;   // entry_count / missing_required_count port width
  localparam int OUT_IDX_W   = 5;   // entry_index port width

  localparam logic       OP_CLEAR      = 1'b1;
  localparam logic [1:0] PROV_NONE     = 2'd0;
  localparam logic [1:0] PROV_PRIMARY  = 2'd1;

  // One table entry as held in the RAM.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  signal_id;
    logic [15:0] name_key;
    logic [3:0]  selected;
    logic [1:0]  provider;
    logic        required;
    logic        low_res;
    logic        covered;
    logic        missing;
  } stm_entry_t;

  localparam int ENTRY_W = $bits(stm_entry_t);

  // Input item as latched at accept.
  typedef struct packed {
    logic        operation;
    logic [1:0]  chunk_kind;
    logic [7:0]  signal_id;
    logic [15:0] name_key;
    logic [3:0]  ideal_source;
    logic [3:0]  chosen_source;
    logic [1:0]  provider_kind;
    logic        is_required;
    logic        is_complete;
  } stm_item_t;

  // Result item.
  typedef struct packed {
    logic                 accepted;
    logic [OUT_IDX_W-1:0] entry_index;
    logic                 was_new;
    logic                 entry_complete;
    logic                 entry_low_res;
    logic [1:0]           entry_provider;
    logic [3:0]           entry_source;
    logic [CNT_W-1:0]     entry_count;
    logic [CNT_W-1:0]     missing_required_count;
  } stm_result_t;

endpackage

`default_nettype wire

>>> rtl/core/stm_table_ram.sv
// ---------------------------------------------------------------------------
// stm_table_ram
// Stream table storage: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stm_table_ram (
  input  wire                        clk,
  input  wire                        wr_en,
  input  wire [stm_pkg::IDX_W-1:0]   wr_addr,
  input  stm_pkg::stm_entry_t        wr_data,
  input  wire                        rd_en,
  input  wire [stm_pkg::IDX_W-1:0]   rd_addr,
  output stm_pkg::stm_entry_t        rd_data
);

  stm_pkg::stm_entry_t mem [stm_pkg::TABLE_DEPTH];
  stm_pkg::stm_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> rtl/core/stream_table_merge.sv
// ---------------------------------------------------------------------------
// stream_table_merge
// Keyed stream table with linear search, merge and append.
// ---------------------------------------------------------------------------
// Flow: clear or empty name go from idle straight to the output state; add scans
//   the valid entries one read per cycle, then merges or appends.
// Throughput: one item at a time; next item accepted once the result is
//   registered, even while it still waits on out_ready.
// Reset: entry and missing counts cleared; table RAM contents are not reset.
`timescale 1ns / 1ps
`default_nettype none

module stream_table_merge (
  input  wire        clk,
  input  wire        rst_n,

  input  wire        in_valid,
  output logic       in_ready,
  input  wire        in_operation,
  input  wire [1:0]  in_chunk_kind,
  input  wire [7:0]  in_signal_id,
  input  wire [15:0] in_name_key,
  input  wire [3:0]  in_ideal_source,
  input  wire [3:0]  in_chosen_source,
  input  wire [1:0]  in_provider_kind,
  input  wire        in_is_required,
  input  wire        in_is_complete,

  output logic       out_valid,
  input  wire        out_ready,
  output logic       out_accepted,
  output logic [4:0] out_entry_index,
  output logic       out_was_new,
  output logic       out_entry_complete,
  output logic       out_entry_low_res,
  output logic [1:0] out_entry_provider,
  output logic [3:0] out_entry_source,
  output logic [5:0] out_entry_count,
  output logic [5:0] out_missing_required_count
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_MERGE  = 3'd2;
  localparam logic [2:0] S_APPEND = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  localparam int IW = stm_pkg::IDX_W;
  localparam int CW = stm_pkg::CNT_W;
  localparam int OW = stm_pkg::OUT_IDX_W;

  logic [2:0]          state_r,   state_nxt;
  logic [CW-1:0]       count_r,   count_nxt;
  logic [CW-1:0]       total_r,   total_nxt;
  logic [CW-1:0]       issue_r,   issue_nxt;
  logic [IW-1:0]       cmp_r,     cmp_nxt;
  logic                pend_r,    pend_nxt;
  logic                out_vld_r, out_vld_nxt;
  stm_pkg::stm_item_t   item_r,   item_nxt;
  stm_pkg::stm_result_t res_r,    res_nxt;
  stm_pkg::stm_result_t out_r,    out_nxt;

  logic                ram_wr_en;
  logic [IW-1:0]       ram_wr_addr;
  stm_pkg::stm_entry_t ram_wr_data;
  logic                ram_rd_en;
  logic [IW-1:0]       ram_rd_addr;
  stm_pkg::stm_entry_t ram_rd_data;

  logic                hit;
  logic                m_cov, m_miss, m_repl, m_new_cnt;
  stm_pkg::stm_entry_t merged;
  stm_pkg::stm_entry_t fresh;

  stm_table_ram u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign in_ready = (state_r == S_IDLE);

  assign hit = pend_r
            && (ram_rd_data.kind      == item_r.chunk_kind)
            && (ram_rd_data.signal_id == item_r.signal_id)
            && (ram_rd_data.name_key  == item_r.name_key);

  // merge of the item into the entry that was hit
  always_comb begin
    m_cov  = ram_rd_data.covered
          | ((item_r.provider_kind != stm_pkg::PROV_NONE) & item_r.is_complete);
    m_miss = ram_rd_data.missing | ~item_r.is_complete;
    m_repl = (item_r.provider_kind == stm_pkg::PROV_PRIMARY)
          || ((ram_rd_data.provider == stm_pkg::PROV_NONE)
              && (item_r.provider_kind != stm_pkg::PROV_NONE))
          || (!item_r.is_complete && !m_cov);
    merged          = ram_rd_data;
    merged.required = ram_rd_data.required | item_r.is_required;
    merged.covered  = m_cov;
    merged.missing  = m_miss;
    merged.low_res  = ram_rd_data.low_res
                    | (item_r.chosen_source != item_r.ideal_source);
    if (m_repl) begin
      merged.selected = item_r.chosen_source;
      merged.provider = item_r.provider_kind;
    end
    // flags are sticky: the entry can only start counting as missing-required
    m_new_cnt = merged.required & m_miss
              & ~(ram_rd_data.required & ram_rd_data.missing);

    fresh.kind      = item_r.chunk_kind;
    fresh.signal_id = item_r.signal_id;
    fresh.name_key  = item_r.name_key;
    fresh.selected  = item_r.chosen_source;
    fresh.provider  = item_r.provider_kind;
    fresh.required  = item_r.is_required;
    fresh.low_res   = (item_r.chosen_source != item_r.ideal_source);
    fresh.covered   = (item_r.provider_kind != stm_pkg::PROV_NONE) & item_r.is_complete;
    fresh.missing   = ~item_r.is_complete;
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    total_nxt   = total_r;
    issue_nxt   = issue_r;
    cmp_nxt     = cmp_r;
    pend_nxt    = pend_r;
    item_nxt    = item_r;
    res_nxt     = res_r;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r & ~out_ready;
    ram_wr_en   = 1'b0;
    ram_wr_addr = cmp_r;
    ram_wr_data = merged;
    ram_rd_en   = 1'b0;
    ram_rd_addr = issue_r[IW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = '{operation:     in_operation,
                       chunk_kind:    in_chunk_kind,
                       signal_id:     in_signal_id,
                       name_key:      in_name_key,
                       ideal_source:  in_ideal_source,
                       chosen_source: in_chosen_source,
                       provider_kind: in_provider_kind,
                       is_required:   in_is_required,
                       is_complete:   in_is_complete};
          res_nxt = '0;
          res_nxt.entry_count            = count_r;
          res_nxt.missing_required_count = total_r;
          if (in_operation == stm_pkg::OP_CLEAR) begin
            count_nxt = '0;
            total_nxt = '0;
            res_nxt.accepted               = 1'b1;
            res_nxt.entry_count            = '0;
            res_nxt.missing_required_count = '0;
            state_nxt = S_OUT;
          end else if (in_name_key == '0) begin
            state_nxt = S_OUT;
          end else begin
            issue_nxt = '0;
            pend_nxt  = 1'b0;
            state_nxt = S_SCAN;
          end
        end
      end

      // one read issued per cycle, compare uses its read data in the cycle after the read
      S_SCAN: begin
        if (hit) begin
          pend_nxt  = 1'b0;
          state_nxt = S_MERGE;
        end else if (issue_r < count_r) begin
          ram_rd_en = 1'b1;
          cmp_nxt   = issue_r[IW-1:0];
          issue_nxt = issue_r + CW'(1);
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_APPEND;
        end
      end

      S_MERGE: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = cmp_r;
        ram_wr_data = merged;
        total_nxt   = total_r + CW'(m_new_cnt);
        res_nxt.accepted               = 1'b1;
        res_nxt.entry_index            = OW'(cmp_r);
        res_nxt.was_new                = 1'b0;
        res_nxt.entry_complete         = ~merged.missing;
        res_nxt.entry_low_res          = merged.low_res;
        res_nxt.entry_provider         = merged.provider;
        res_nxt.entry_source           = merged.selected;
        res_nxt.entry_count            = count_r;
        res_nxt.missing_required_count = total_nxt;
        state_nxt = S_OUT;
      end

      S_APPEND: begin
        if (count_r < CW'(stm_pkg::TABLE_DEPTH)) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = count_r[IW-1:0];
          ram_wr_data = fresh;
          count_nxt   = count_r + CW'(1);
          total_nxt   = total_r + CW'(fresh.required & fresh.missing);
          res_nxt.accepted       = 1'b1;
          res_nxt.entry_index    = OW'(count_r[IW-1:0]);
          res_nxt.was_new        = 1'b1;
          res_nxt.entry_complete = ~fresh.missing;
          res_nxt.entry_low_res  = fresh.low_res;
          res_nxt.entry_provider = fresh.provider;
          res_nxt.entry_source   = fresh.selected;
        end
        // table full: result already holds the failure pattern
        res_nxt.entry_count            = count_nxt;
        res_nxt.missing_required_count = total_nxt;
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (!out_vld_r || out_ready) begin
          out_nxt     = res_r;
          out_vld_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      total_r   <= '0;
      pend_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      total_r   <= total_nxt;
      pend_r    <= pend_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    issue_r <= issue_nxt;
    cmp_r   <= cmp_nxt;
    item_r  <= item_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid                  = out_vld_r;
  assign out_accepted               = out_r.accepted;
  assign out_entry_index            = out_r.entry_index;
  assign out_was_new                = out_r.was_new;
  assign out_entry_complete         = out_r.entry_complete;
  assign out_entry_low_res          = out_r.entry_low_res;
  assign out_entry_provider         = out_r.entry_provider;
  assign out_entry_source           = out_r.entry_source;
  assign out_entry_count            = out_r.entry_count;
  assign out_missing_required_count = out_r.missing_required_count;

  `include "stream_table_merge_assert.svh"

  `STM_ASSERT_NOW(a_count_range, 1'b1, count_r <= CW'(stm_pkg::TABLE_DEPTH), "count past depth")
  `STM_ASSERT_NOW(a_total_le_count, 1'b1, total_r <= count_r, "missing count over entry count")
  `STM_ASSERT_NOW(a_cmp_in_table, state_r == S_SCAN && pend_r, CW'(cmp_r) < count_r, "bad compare")
  `STM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accept while busy")
  `STM_ASSERT_NOW(a_write_in_update, ram_wr_en, state_r == S_MERGE || state_r == S_APPEND, "stray write")

endmodule

`default_nettype wire
